### hw/rtl/midi_pkg.sv
// Shared types and constants for the MIDI track event parser.
// No dependencies; used by midi_step and midi_track_event_parser_unit.
`timescale 1ns / 1ps
`default_nettype none

package midi_pkg;

   typedef enum logic [3:0] {
      PH_HUNT      = 4'd0,
      PH_LEN       = 4'd1,
      PH_DELTA     = 4'd2,
      PH_STATUS    = 4'd3,
      PH_META_TYPE = 4'd4,
      PH_META_LEN  = 4'd5,
      PH_META_DATA = 4'd6,
      PH_SYSEX     = 4'd7,
      PH_DATA1     = 4'd8,
      PH_DATA2     = 4'd9
   } midi_phase_type;

   typedef enum logic [3:0] {
      EV_NOTE_ON   = 4'd0,
      EV_NOTE_OFF  = 4'd1,
      EV_CTRL      = 4'd2,
      EV_PROG      = 4'd3,
      EV_SEQNUM    = 4'd4,
      EV_TEMPO     = 4'd5,
      EV_TIMESIG   = 4'd6,
      EV_KEYSIG    = 4'd7,
      EV_END       = 4'd8,
      EV_SYSEX     = 4'd9,
      EV_OTHERMETA = 4'd10,
      EV_HEADERR   = 4'd11,
      EV_BADSTATUS = 4'd12
   } midi_kind_type;

   // upper nibble of channel statuses that are handled
   localparam logic [3:0] HI_NOTE_OFF = 4'h8;
   localparam logic [3:0] HI_NOTE_ON  = 4'h9;
   localparam logic [3:0] HI_CTRL     = 4'hB;
   localparam logic [3:0] HI_PROG     = 4'hC;

   localparam logic [7:0] STATUS_SYSEX   = 8'hF0;
   localparam logic [7:0] STATUS_SYSEX_END = 8'hF7;
   localparam logic [7:0] STATUS_META    = 8'hFF;

   localparam logic [7:0] META_SEQNUM  = 8'h00;
   localparam logic [7:0] META_END     = 8'h2F;
   localparam logic [7:0] META_TEMPO   = 8'h51;
   localparam logic [7:0] META_TIMESIG = 8'h58;
   localparam logic [7:0] META_KEYSIG  = 8'h59;

   localparam logic [7:0] MAGIC_FIRST = 8'h4D;

   typedef struct packed {
      midi_phase_type phase;
      logic [2:0]     byte_count;
      logic [7:0]     running_status;
      logic [31:0]    tick_total;
      logic [31:0]    length_accum;
      logic [7:0]     meta_kind;
      logic [31:0]    meta_left;
      logic [31:0]    value_accum;
      logic [6:0]     first_data;
   } midi_state_type;

   typedef struct packed {
      midi_kind_type kind;
      logic [3:0]    channel;
      logic [7:0]    key_or_number;
      logic [6:0]    velocity_or_value;
      logic [31:0]   meta_value;
      logic [31:0]   running_time;
   } midi_result_type;

   // "MTrk"
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h4D;
         2'd1:    val = 8'h54;
         2'd2:    val = 8'h72;
         2'd3:    val = 8'h6B;
         default: val = 8'h4D;
      endcase
      return val;
   endfunction

   function automatic logic is_chan_hi(input logic [3:0] hi);
      return (hi == HI_NOTE_OFF) || (hi == HI_NOTE_ON) || (hi == HI_CTRL) || (hi == HI_PROG);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/midi_step.sv
// Combinational next-state and result logic for one track byte.
// Depends on midi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module midi_step (
   input  wire midi_pkg::midi_state_type cur,
   input  wire logic [7:0]               data_byte,
   input  wire logic                     restart,
   output midi_pkg::midi_state_type      nxt,
   output logic                          emit,
   output midi_pkg::midi_result_type     res
);
   import midi_pkg::*;

   midi_phase_type ph;
   logic [2:0]     bc;
   logic [3:0]     hi;
   logic [3:0]     ch;
   logic [6:0]     b7;
   logic           cont;
   logic [31:0]    len7;
   logic [31:0]    va7;
   logic [31:0]    va8;
   logic [31:0]    left_dec;
   logic [31:0]    fin_va;
   midi_kind_type  fm_kind;
   logic [31:0]    fm_value;

   assign ph       = restart ? PH_HUNT : cur.phase;
   assign bc       = restart ? 3'd0 : cur.byte_count;
   assign hi       = cur.running_status[7:4];
   assign ch       = cur.running_status[3:0];
   assign b7       = data_byte[6:0];
   assign cont     = data_byte[7];
   assign len7     = {cur.length_accum[24:0], b7};
   assign va7      = {cur.value_accum[24:0], b7};
   assign va8      = {cur.value_accum[23:0], data_byte};
   assign left_dec = cur.meta_left - 32'd1;
   assign fin_va   = (ph == PH_META_DATA) ? va8 : 32'd0;

   // meta decode at the last data byte (or at a zero length)
   always_comb begin
      fm_kind  = EV_OTHERMETA;
      fm_value = 32'd0;
      case (cur.meta_kind)
         META_SEQNUM: begin
            if (cur.length_accum == 32'd2) begin
               fm_kind  = EV_SEQNUM;
               fm_value = {16'd0, fin_va[15:0]};
            end
         end
         META_TEMPO: begin
            if (cur.length_accum == 32'd3) begin
               fm_kind  = EV_TEMPO;
               fm_value = {8'd0, fin_va[23:0]};
            end
         end
         META_TIMESIG: begin
            if (cur.length_accum == 32'd4) begin
               fm_kind  = EV_TIMESIG;
               fm_value = fin_va;
            end
         end
         META_KEYSIG: begin
            if (cur.length_accum == 32'd2) begin
               fm_kind  = EV_KEYSIG;
               fm_value = {16'd0, fin_va[15:0]};
            end
         end
         META_END: begin
            fm_kind = EV_END;
         end
         default: begin
            fm_kind = EV_OTHERMETA;
         end
      endcase
   end

   always_comb begin
      nxt                   = cur;
      nxt.phase             = ph;
      nxt.byte_count        = bc;
      emit                  = 1'b0;
      res.kind              = EV_HEADERR;
      res.channel           = 4'd0;
      res.key_or_number     = 8'd0;
      res.velocity_or_value = 7'd0;
      res.meta_value        = 32'd0;

      case (ph)
         PH_HUNT: begin
            if (data_byte == magic_byte(bc[1:0])) begin
               if (bc == 3'd3) begin
                  nxt.byte_count   = 3'd0;
                  nxt.length_accum = 32'd0;
                  nxt.phase        = PH_LEN;
               end else begin
                  nxt.byte_count = bc + 3'd1;
               end
            end else begin
               nxt.byte_count    = (data_byte == MAGIC_FIRST) ? 3'd1 : 3'd0;
               emit              = 1'b1;
               res.kind          = EV_HEADERR;
               res.key_or_number = data_byte;
            end
         end
         PH_LEN: begin
            nxt.length_accum = {cur.length_accum[23:0], data_byte};
            if (bc == 3'd3) begin
               nxt.byte_count     = 3'd0;
               nxt.tick_total     = 32'd0;
               nxt.running_status = 8'd0;
               nxt.value_accum    = 32'd0;
               nxt.phase          = PH_DELTA;
            end else begin
               nxt.byte_count = bc + 3'd1;
            end
         end
         PH_DELTA: begin
            nxt.value_accum = va7;
            if (!cont) begin
               nxt.tick_total  = cur.tick_total + va7;
               nxt.value_accum = 32'd0;
               nxt.phase       = PH_STATUS;
            end
         end
         PH_STATUS: begin
            if (!cont) begin
               if (is_chan_hi(hi)) begin
                  nxt.first_data = b7;
                  if (hi == HI_PROG) begin
                     nxt.phase         = PH_DELTA;
                     nxt.value_accum   = 32'd0;
                     emit              = 1'b1;
                     res.kind          = EV_PROG;
                     res.channel       = ch;
                     res.key_or_number = {1'b0, b7};
                  end else begin
                     nxt.phase = PH_DATA2;
                  end
               end else begin
                  nxt.phase         = PH_HUNT;
                  nxt.byte_count    = 3'd0;
                  emit              = 1'b1;
                  res.kind          = EV_BADSTATUS;
                  res.key_or_number = data_byte;
               end
            end else if (data_byte == STATUS_META) begin
               nxt.running_status = 8'd0;
               nxt.phase          = PH_META_TYPE;
            end else if (data_byte == STATUS_SYSEX || data_byte == STATUS_SYSEX_END) begin
               nxt.running_status = 8'd0;
               nxt.phase          = PH_SYSEX;
            end else if (is_chan_hi(data_byte[7:4])) begin
               nxt.running_status = data_byte;
               nxt.phase          = PH_DATA1;
            end else begin
               nxt.running_status = 8'd0;
               nxt.phase          = PH_HUNT;
               nxt.byte_count     = 3'd0;
               emit               = 1'b1;
               res.kind           = EV_BADSTATUS;
               res.key_or_number  = data_byte;
            end
         end
         PH_META_TYPE: begin
            nxt.meta_kind    = data_byte;
            nxt.length_accum = 32'd0;
            nxt.phase        = PH_META_LEN;
         end
         PH_META_LEN, PH_META_DATA: begin
            if (ph == PH_META_LEN) begin
               nxt.length_accum = len7;
               if (!cont) begin
                  nxt.meta_left   = len7;
                  nxt.value_accum = 32'd0;
                  nxt.phase       = PH_META_DATA;
               end
            end else begin
               nxt.value_accum = va8;
               nxt.meta_left   = left_dec;
            end
            // zero length ends at the length byte, otherwise at the last data byte
            if ((ph == PH_META_LEN && !cont && len7 == 32'd0) ||
                (ph == PH_META_DATA && left_dec == 32'd0)) begin
               nxt.value_accum   = 32'd0;
               emit              = 1'b1;
               res.kind          = fm_kind;
               res.key_or_number = cur.meta_kind;
               res.meta_value    = fm_value;
               if (fm_kind == EV_END) begin
                  nxt.phase      = PH_HUNT;
                  nxt.byte_count = 3'd0;
               end else begin
                  nxt.phase = PH_DELTA;
               end
            end
         end
         PH_SYSEX: begin
            if (data_byte == STATUS_SYSEX_END) begin
               nxt.phase       = PH_DELTA;
               nxt.value_accum = 32'd0;
               emit            = 1'b1;
               res.kind        = EV_SYSEX;
            end
         end
         PH_DATA1: begin
            nxt.first_data = b7;
            if (hi == HI_PROG) begin
               nxt.phase         = PH_DELTA;
               nxt.value_accum   = 32'd0;
               emit              = 1'b1;
               res.kind          = EV_PROG;
               res.channel       = ch;
               res.key_or_number = {1'b0, b7};
            end else begin
               nxt.phase = PH_DATA2;
            end
         end
         PH_DATA2: begin
            nxt.phase         = PH_DELTA;
            nxt.value_accum   = 32'd0;
            emit              = 1'b1;
            res.channel       = ch;
            res.key_or_number = {1'b0, cur.first_data};
            if (hi == HI_NOTE_OFF || (hi == HI_NOTE_ON && b7 == 7'd0)) begin
               res.kind = EV_NOTE_OFF;
            end else if (hi == HI_NOTE_ON) begin
               res.kind              = EV_NOTE_ON;
               res.velocity_or_value = b7;
            end else begin
               res.kind              = EV_CTRL;
               res.velocity_or_value = b7;
            end
         end
         default: begin
            nxt.phase      = PH_HUNT;
            nxt.byte_count = 3'd0;
         end
      endcase

      res.running_time = nxt.tick_total;
   end

endmodule

`default_nettype wire

### hw/rtl/midi_track_event_parser_unit.sv
// Top level of the MIDI track event parser: parser state, result register, handshakes.
// Depends on midi_pkg and midi_step.
//
// Usage:
//  - req channel carries the raw track chunk one byte per request, starting at the
//    "MTrk" magic. req_tuser high restarts the header hunt with that byte.
//  - Each request yields zero or one result on the rsp channel: note on/off,
//    controller, program, metas (decoded or other), sysex, end of track, or an error
//    (bad magic byte, unknown status). running_time is the wrapped tick count.
//  - Output: a registered result shows on rsp in the cycle after its completing request.
//  - Throughput: one byte per cycle unless rsp stalls; the whole byte update is one pass
//    of small shift/add logic between the parser state and the result register.
//  - Stall: the single result register holds its result while rsp_tready is low;
//    req_tready drops only while that register is full and not being drained,
//    so a stalled receiver stops the input after at most one pending result.
//  - Reset: synchronous, active high; parser returns to header hunt with all
//    counters and running status cleared, and the result register is emptied.
//  - Errors do not stop the stream: the parser simply hunts for the next magic.
`timescale 1ns / 1ps
`default_nettype none

module midi_track_event_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] restart
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [87:0]      rsp_tdata,   // [3:0] channel, [11:4] key_or_number,
                                         // [18:12] velocity_or_value, [50:19] meta_value,
                                         // [82:51] running_time, [87:83] zero
   output logic [3:0]       rsp_tuser    // [3:0] event_kind
);
   import midi_pkg::*;

   midi_state_type  state_ff;
   midi_state_type  state_in;
   midi_result_type result_ff;
   midi_result_type step_res;
   logic            step_emit;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            req_fire;

   midi_step u_step (
      .cur       (state_ff),
      .data_byte (req_tdata),
      .restart   (req_tuser),
      .nxt       (state_in),
      .emit      (step_emit),
      .res       (step_res)
   );

   // take a new byte whenever the result slot is free or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      if (req_fire) begin
         rsp_valid_in = step_emit;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= PH_HUNT;
         state_ff.byte_count     <= 3'd0;
         state_ff.running_status <= 8'd0;
         state_ff.tick_total     <= 32'd0;
         state_ff.length_accum   <= 32'd0;
         state_ff.meta_kind      <= 8'd0;
         state_ff.meta_left      <= 32'd0;
         state_ff.value_accum    <= 32'd0;
         state_ff.first_data     <= 7'd0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            state_ff <= state_in;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_fire && step_emit) begin
         result_ff <= step_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = result_ff.kind;
   assign rsp_tdata  = {5'd0, result_ff.running_time, result_ff.meta_value,
                        result_ff.velocity_or_value, result_ff.key_or_number,
                        result_ff.channel};

   // header hunt never indexes past the last magic byte
   a_hunt_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_HUNT || state_ff.phase == PH_LEN) |-> state_ff.byte_count <= 3'd3)
      else $error("byte count out of range");

   // end of track and errors send the parser back to header hunt
   a_end_hunt: assert property (@(posedge clock) disable iff (reset)
      (req_fire && step_emit && (step_res.kind == EV_END || step_res.kind == EV_HEADERR ||
       step_res.kind == EV_BADSTATUS)) |=> state_ff.phase == PH_HUNT)
      else $error("no return to header hunt");

   // a channel event leaves a usable running status behind
   a_chan_status: assert property (@(posedge clock) disable iff (reset)
      (req_fire && step_emit && (step_res.kind == EV_NOTE_ON || step_res.kind == EV_NOTE_OFF ||
       step_res.kind == EV_CTRL || step_res.kind == EV_PROG))
      |=> is_chan_hi(state_ff.running_status[7:4]))
      else $error("channel event without running status");

   // non-channel events report channel zero
   a_chan_zero: assert property (@(posedge clock) disable iff (reset)
      (req_fire && step_emit && !(step_res.kind == EV_NOTE_ON || step_res.kind == EV_NOTE_OFF ||
       step_res.kind == EV_CTRL || step_res.kind == EV_PROG)) |-> step_res.channel == 4'd0)
      else $error("channel set on non-channel event");

   // a pending result is not overwritten while stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_fire)
      else $error("request taken while result stalled");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking bench for midi_track_event_parser_unit: byte stream in, parsed events out.
// Depends on midi_pkg and the parser RTL; a built-in track decoder predicts each event.
`timescale 1ns / 1ps

module testbench;
   import midi_pkg::*;

   // "MTrk", first byte in the top bits
   localparam logic [31:0] TRACK_TAG      = 32'h4D54726B;
   localparam int          RANDOM_BYTES   = 510;   // random track part stops here
   localparam int          NOISE_BYTES    = 40;
   localparam int          STALL_LIMIT    = 4000;  // cycles with no request or result moving
   localparam int          DRAIN_CYCLES   = 4;     // result shows in the cycle after its request
   localparam int          REPORT_LIMIT   = 40;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // [7:0] data_byte
   logic        req_tuser  = 1'b0;   // [0] restart
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;           // [3:0] channel, [11:4] key_or_number,
                                     // [18:12] velocity_or_value, [50:19] meta_value,
                                     // [82:51] running_time, [87:83] zero
   logic [3:0]  rsp_tuser;           // [3:0] event_kind

   midi_track_event_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Track decoder state (reset values)
   // ---------------------------------------------------------------
   midi_phase_type  trk_phase      = PH_HUNT;
   logic [2:0]      tag_idx        = 3'd0;
   logic [7:0]      run_status     = 8'd0;
   logic [31:0]     tick_count     = 32'd0;
   logic [31:0]     len_accum      = 32'd0;
   logic [7:0]      meta_type      = 8'd0;
   logic [31:0]     meta_remaining = 32'd0;
   logic [31:0]     value_shift    = 32'd0;
   logic [6:0]      held_key       = 7'd0;

   midi_result_type pending_events[$];   // events still owed by the DUT
   int              bytes_sent     = 0;
   int              mismatch_count = 0;
   int              burst_left     = 0;

   function automatic logic [7:0] tag_byte(input int idx);
      return TRACK_TAG[8 * (3 - idx) +: 8];
   endfunction

   function automatic bit handled_nibble(input logic [3:0] hi);
      bit ok;
      case (hi)
         HI_NOTE_OFF, HI_NOTE_ON, HI_CTRL, HI_PROG: ok = 1'b1;
         default:                                   ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic midi_result_type build_event(input midi_kind_type kind,
                                                   input logic [3:0] chan,
                                                   input logic [7:0] key,
                                                   input logic [6:0] vel,
                                                   input logic [31:0] mval);
      midi_result_type ev;
      ev.kind              = kind;
      ev.channel           = chan;
      ev.key_or_number     = key;
      ev.velocity_or_value = vel;
      ev.meta_value        = mval;
      ev.running_time      = tick_count;
      return ev;
   endfunction

   // first data byte of a channel event; program change completes here
   function automatic bit latch_key_byte(input logic [7:0] b, output midi_result_type ev);
      held_key = b[6:0];
      ev = '0;
      if (run_status[7:4] == HI_PROG) begin
         trk_phase   = PH_DELTA;
         value_shift = 32'd0;
         ev = build_event(EV_PROG, run_status[3:0], {1'b0, held_key}, 7'd0, 32'd0);
         return 1'b1;
      end
      trk_phase = PH_DATA2;
      return 1'b0;
   endfunction

   // known metas decode only at their proper length; end of track ends the track
   function automatic midi_result_type meta_result();
      midi_kind_type kind;
      logic [31:0]   mval;
      kind = EV_OTHERMETA;
      mval = 32'd0;
      case (meta_type)
         META_SEQNUM:  if (len_accum == 32'd2) begin
            kind = EV_SEQNUM;
            mval = {16'd0, value_shift[15:0]};
         end
         META_TEMPO:   if (len_accum == 32'd3) begin
            kind = EV_TEMPO;
            mval = {8'd0, value_shift[23:0]};
         end
         META_TIMESIG: if (len_accum == 32'd4) begin
            kind = EV_TIMESIG;
            mval = value_shift;
         end
         META_KEYSIG:  if (len_accum == 32'd2) begin
            kind = EV_KEYSIG;
            mval = {16'd0, value_shift[15:0]};
         end
         META_END:     kind = EV_END;
         default:      ;
      endcase
      if (kind == EV_END) begin
         trk_phase = PH_HUNT;
         tag_idx   = 3'd0;
      end else begin
         trk_phase = PH_DELTA;
      end
      value_shift = 32'd0;
      return build_event(kind, 4'd0, meta_type, 7'd0, mval);
   endfunction

   // advance the decoder by one byte; returns 1 when an event is due
   function automatic bit parse_track_byte(input logic [7:0] b, input logic rst,
                                           output midi_result_type ev);
      bit produced;
      produced = 1'b0;
      ev = '0;
      if (rst) begin
         trk_phase = PH_HUNT;
         tag_idx   = 3'd0;
      end
      case (trk_phase)
         PH_HUNT: begin
            if (b == tag_byte(tag_idx)) begin
               tag_idx = tag_idx + 3'd1;
               if (tag_idx == 3'd4) begin
                  tag_idx   = 3'd0;
                  len_accum = 32'd0;
                  trk_phase = PH_LEN;
               end
            end else begin
               // a stray 'M' still starts a new match
               tag_idx  = (b == MAGIC_FIRST) ? 3'd1 : 3'd0;
               ev       = build_event(EV_HEADERR, 4'd0, b, 7'd0, 32'd0);
               produced = 1'b1;
            end
         end
         PH_LEN: begin
            len_accum = {len_accum[23:0], b};
            tag_idx   = tag_idx + 3'd1;
            if (tag_idx == 3'd4) begin
               tag_idx     = 3'd0;
               tick_count  = 32'd0;
               run_status  = 8'd0;
               value_shift = 32'd0;
               trk_phase   = PH_DELTA;
            end
         end
         PH_DELTA: begin
            value_shift = {value_shift[24:0], b[6:0]};
            if (!b[7]) begin
               tick_count  = tick_count + value_shift;
               value_shift = 32'd0;
               trk_phase   = PH_STATUS;
            end
         end
         PH_STATUS: begin
            if (!b[7]) begin
               if (handled_nibble(run_status[7:4])) begin
                  produced = latch_key_byte(b, ev);
               end else begin
                  trk_phase = PH_HUNT;
                  tag_idx   = 3'd0;
                  ev        = build_event(EV_BADSTATUS, 4'd0, b, 7'd0, 32'd0);
                  produced  = 1'b1;
               end
            end else if (b == STATUS_META) begin
               run_status = 8'd0;
               trk_phase  = PH_META_TYPE;
            end else if (b == STATUS_SYSEX || b == STATUS_SYSEX_END) begin
               run_status = 8'd0;
               trk_phase  = PH_SYSEX;
            end else if (handled_nibble(b[7:4])) begin
               run_status = b;
               trk_phase  = PH_DATA1;
            end else begin
               run_status = 8'd0;
               trk_phase  = PH_HUNT;
               tag_idx    = 3'd0;
               ev         = build_event(EV_BADSTATUS, 4'd0, b, 7'd0, 32'd0);
               produced   = 1'b1;
            end
         end
         PH_META_TYPE: begin
            meta_type = b;
            len_accum = 32'd0;
            trk_phase = PH_META_LEN;
         end
         PH_META_LEN: begin
            len_accum = {len_accum[24:0], b[6:0]};
            if (!b[7]) begin
               meta_remaining = len_accum;
               value_shift    = 32'd0;
               if (meta_remaining == 32'd0) begin
                  ev       = meta_result();
                  produced = 1'b1;
               end else begin
                  trk_phase = PH_META_DATA;
               end
            end
         end
         PH_META_DATA: begin
            value_shift    = {value_shift[23:0], b};
            meta_remaining = meta_remaining - 32'd1;
            if (meta_remaining == 32'd0) begin
               ev       = meta_result();
               produced = 1'b1;
            end
         end
         PH_SYSEX: begin
            if (b == STATUS_SYSEX_END) begin
               trk_phase   = PH_DELTA;
               value_shift = 32'd0;
               ev          = build_event(EV_SYSEX, 4'd0, 8'd0, 7'd0, 32'd0);
               produced    = 1'b1;
            end
         end
         PH_DATA1: produced = latch_key_byte(b, ev);
         PH_DATA2: begin
            trk_phase   = PH_DELTA;
            value_shift = 32'd0;
            produced    = 1'b1;
            if (run_status[7:4] == HI_NOTE_OFF ||
                (run_status[7:4] == HI_NOTE_ON && b[6:0] == 7'd0))
               ev = build_event(EV_NOTE_OFF, run_status[3:0], {1'b0, held_key}, 7'd0, 32'd0);
            else if (run_status[7:4] == HI_NOTE_ON)
               ev = build_event(EV_NOTE_ON, run_status[3:0], {1'b0, held_key}, b[6:0], 32'd0);
            else
               ev = build_event(EV_CTRL, run_status[3:0], {1'b0, held_key}, b[6:0], 32'd0);
         end
         default: begin
            trk_phase = PH_HUNT;
            tag_idx   = 3'd0;
         end
      endcase
      return produced;
   endfunction

   // ---------------------------------------------------------------
   // Request side: one byte per request, bursts with random gaps.
   // ready is sampled at the falling edge, where nothing is changing.
   // ---------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic rst);
      midi_result_type ev;
      int              gap;
      logic            taken;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= rst;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      if (parse_track_byte(b, rst, ev))
         pending_events.push_back(ev);
      bytes_sent++;
   endtask

   // data byte for channel events; sometimes with the top bit set
   function automatic logic [7:0] rand_data();
      logic [7:0] d;
      d = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(0, 127));
      if ($urandom_range(0, 9) == 0)
         d[7] = 1'b1;
      return d;
   endfunction

   task automatic send_meta(input logic [7:0] mtype, input int mlen);
      send_byte(STATUS_META, 1'b0);
      send_byte(mtype, 1'b0);
      // redundant leading group exercises multi-byte lengths
      if ($urandom_range(0, 6) == 0)
         send_byte(8'h80, 1'b0);
      send_byte(8'(mlen), 1'b0);
      repeat (mlen) send_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   // ---------------------------------------------------------------
   // Result side: stall pattern and checker
   // ---------------------------------------------------------------
   initial begin : rsp_stall_pattern
      int mode;
      int left;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(8, 60);
         end
         left--;
         case (mode)
            0:       rsp_tready <= 1'b1;                         // no stalls
            1:       rsp_tready <= ($urandom_range(0, 3) != 0);
            2:       rsp_tready <= ($urandom_range(0, 1) != 0);
            default: rsp_tready <= ((left % 8) == 0);            // long stalls
         endcase
      end
   end

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         if (mismatch_count < REPORT_LIMIT)
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   always @(negedge clock) begin : rsp_monitor
      midi_result_type seen;
      midi_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.kind              = midi_kind_type'(rsp_tuser);
         seen.channel           = rsp_tdata[3:0];
         seen.key_or_number     = rsp_tdata[11:4];
         seen.velocity_or_value = rsp_tdata[18:12];
         seen.meta_value        = rsp_tdata[50:19];
         seen.running_time      = rsp_tdata[82:51];
         if (pending_events.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
               $display("%0t ns: unexpected event, expected none, actual kind %0d key %0h",
                        $time, seen.kind, seen.key_or_number);
            mismatch_count++;
         end else begin
            want = pending_events.pop_front();
            check_field("event_kind", 32'(want.kind), 32'(seen.kind));
            check_field("channel", 32'(want.channel), 32'(seen.channel));
            check_field("key_or_number", 32'(want.key_or_number), 32'(seen.key_or_number));
            check_field("velocity_or_value", 32'(want.velocity_or_value),
                        32'(seen.velocity_or_value));
            check_field("meta_value", want.meta_value, seen.meta_value);
            check_field("running_time", want.running_time, seen.running_time);
         end
      end
   end

   // nothing moving on either channel for too long means a hang
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(negedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle = 0;
         else
            idle++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // junk byte, then "M T M" (the second M restarts the match), then
   // the rest of the tag and an all-ones chunk length
   task automatic test_header_hunt();
      send_byte(8'h00, 1'b0);
      send_byte(tag_byte(0), 1'b0);
      send_byte(tag_byte(1), 1'b0);
      send_byte(tag_byte(0), 1'b0);
      send_byte(tag_byte(1), 1'b0);
      send_byte(tag_byte(2), 1'b0);
      send_byte(tag_byte(3), 1'b0);
      repeat (4) send_byte(8'hFF, 1'b0);
   endtask

   // five-byte delta that overflows 32 bits, note-on with zero velocity
   // and top-bit key, then a running-status note-on at full velocity
   task automatic test_channel_events();
      repeat (4) send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte({HI_NOTE_ON, 4'hF}, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h3C, 1'b0);
      send_byte(8'h7F, 1'b0);
   endtask

   // sysex opened by the end byte, time signature with zero length,
   // then a data byte with no running status (back to hunt)
   task automatic test_meta_sysex_errors();
      send_byte(8'h00, 1'b0);
      send_byte(STATUS_SYSEX_END, 1'b0);
      send_byte(STATUS_SYSEX_END, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(STATUS_META, 1'b0);
      send_byte(META_TIMESIG, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h45, 1'b0);
   endtask

   // well-formed tracks with random content, mixed with bad statuses,
   // stray bytes and tracks cut short by a restart
   task automatic test_random_tracks();
      int         n_events;
      int         i;
      int         n;
      int         pick;
      int         mlen;
      logic [3:0] hi;
      logic [3:0] chan;
      logic [7:0] mtype;
      logic [7:0] b;
      while (bytes_sent < RANDOM_BYTES) begin
         send_byte(tag_byte(0), (trk_phase != PH_HUNT) || ($urandom_range(0, 7) == 0));
         send_byte(tag_byte(1), 1'b0);
         send_byte(tag_byte(2), 1'b0);
         send_byte(tag_byte(3), 1'b0);
         repeat (4) send_byte(8'($urandom_range(0, 255)), 1'b0);
         n_events = $urandom_range(2, 14);
         for (i = 0; i < n_events && trk_phase != PH_HUNT; i++) begin
            // delta time, mostly one byte
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : 1;
            repeat (n - 1) send_byte(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
            send_byte(8'($urandom_range(0, 127)), 1'b0);
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
               case ($urandom_range(0, 3))
                  0:       hi = HI_NOTE_OFF;
                  1:       hi = HI_NOTE_ON;
                  2:       hi = HI_CTRL;
                  default: hi = HI_PROG;
               endcase
               chan = 4'($urandom_range(0, 15));
               send_byte({hi, chan}, 1'b0);
               send_byte(rand_data(), 1'b0);
               if (hi != HI_PROG)
                  send_byte(rand_data(), 1'b0);
            end else if (pick < 55) begin
               // running status; after a meta or sysex this is a bad status
               send_byte(rand_data() & 8'h7F, 1'b0);
               if (run_status != 8'd0 && run_status[7:4] != HI_PROG)
                  send_byte(rand_data(), 1'b0);
            end else if (pick < 77) begin
               case ($urandom_range(0, 9))
                  0, 1:    begin mtype = META_SEQNUM;  mlen = 2; end
                  2, 3:    begin mtype = META_TEMPO;   mlen = 3; end
                  4, 5:    begin mtype = META_TIMESIG; mlen = 4; end
                  6, 7:    begin mtype = META_KEYSIG;  mlen = 2; end
                  8:       begin mtype = META_END;     mlen = 0; end
                  default: begin
                     mtype = 8'($urandom_range(0, 255));
                     mlen  = $urandom_range(0, 7);
                  end
               endcase
               if ($urandom_range(0, 4) == 0)
                  mlen = $urandom_range(0, 7);
               send_meta(mtype, mlen);
            end else if (pick < 87) begin
               send_byte(($urandom_range(0, 1) == 0) ? STATUS_SYSEX : STATUS_SYSEX_END, 1'b0);
               repeat ($urandom_range(0, 5)) begin
                  b = 8'($urandom_range(0, 255));
                  send_byte((b == STATUS_SYSEX_END) ? STATUS_SYSEX : b, 1'b0);
               end
               send_byte(STATUS_SYSEX_END, 1'b0);
            end else if (pick < 93) begin
               // unsupported status ranges
               case ($urandom_range(0, 3))
                  0:       b = 8'hA0 + 8'($urandom_range(0, 15));
                  1:       b = 8'hD0 + 8'($urandom_range(0, 31));
                  2:       b = 8'hF1 + 8'($urandom_range(0, 5));
                  default: b = 8'hF8 + 8'($urandom_range(0, 6));
               endcase
               send_byte(b, 1'b0);
            end else begin
               repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
         end
         // most tracks close properly; the others get cut by the next restart
         if (trk_phase == PH_DELTA && $urandom_range(0, 3) != 0) begin
            send_byte(8'($urandom_range(0, 127)), 1'b0);
            send_meta(META_END, 0);
         end
      end
   endtask

   // raw bytes with random restarts, some of them tag bytes
   task automatic test_line_noise();
      repeat (NOISE_BYTES) begin
         if ($urandom_range(0, 3) == 0)
            send_byte(tag_byte($urandom_range(0, 3)), $urandom_range(0, 7) == 0);
         else
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_header_hunt();
      test_channel_events();
      test_meta_sysex_errors();
      test_random_tracks();
      test_line_noise();
      req_tvalid <= 1'b0;
      // the watchdog bounds this wait
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### files.f
hw/rtl/midi_pkg.sv
hw/rtl/midi_step.sv
hw/rtl/midi_track_event_parser_unit.sv
tb/sv/testbench.sv
